// ===== hw/rtl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types and constants for the running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int RMTH_CAPACITY = 1024;
    localparam int SAMPLE_W      = 32;
    localparam int MEDIAN_W      = 33;
    localparam int COUNT_W       = 11;
    localparam int OUT_TDATA_W   = 48;

    typedef enum logic
    {
        HEAP_PUSH,
        HEAP_REPLACE
    } heap_op_t;

    typedef struct packed
    {
        logic                       valid;
        heap_op_t                   op;
        logic signed [SAMPLE_W-1:0] value;
    } heap_cmd_t;

endpackage

// ===== hw/rtl/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Streaming exact median of signed samples, kept in a max-heap of the lower
// half and a min-heap of the upper half, each in its own RAM.
//
// Channel   Dir  Payload                                      Words
// s_axis    in   tdata[31:0] sample                           one per sample
// m_axis    out  tdata median_doubled, stored_count; tuser    one per sample
//
// The block takes no new sample until the result of the last one is loaded into
// the output register; the work is at most one replace-top sift down and one push
// sift up, each one heap level per cycle over the heap RAMs. A full store skips
// the heaps and goes straight to the result state.
// Reset clears the heap sizes and the registers; no clearing pass over the RAMs.
// A stalled result waits in the output register; the next sample is taken.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
    parameter int CAPACITY = rmth_pkg::RMTH_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] sample
    input  logic [rmth_pkg::SAMPLE_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [32:0] median_doubled, [43:33] stored_count, [47:44] zero
    output logic [rmth_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] rejected
    output logic [0:0]                          m_axis_tuser
);

    import rmth_pkg::*;

    localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
    localparam int UPPER_DEPTH = CAPACITY / 2;
    localparam int LSW         = $clog2(LOWER_DEPTH + 1);
    localparam int USW         = $clog2(UPPER_DEPTH + 1);
    localparam int CW          = $clog2(CAPACITY + 1);

    typedef enum logic [1:0]
    {
        T_IDLE,
        T_FIRST,
        T_RESULT
    } tstate_t;

    tstate_t                    state_reg;
    logic                       second_pend_reg;
    logic                       second_upper_reg;
    logic signed [SAMPLE_W-1:0] second_val_reg;
    logic                       rej_reg;
    logic                       m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]     m_tdata_reg;
    logic                       m_tuser_reg;

    heap_cmd_t                  lower_cmd;
    heap_cmd_t                  upper_cmd;
    logic                       lower_busy;
    logic                       upper_busy;
    logic signed [SAMPLE_W-1:0] lower_top;
    logic signed [SAMPLE_W-1:0] upper_top;
    logic [LSW-1:0]             lower_size;
    logic [USW-1:0]             upper_size;

    logic signed [SAMPLE_W-1:0] v;
    logic                       accept;
    logic                       full;
    logic                       lower_extra;
    logic                       lower_repl;
    logic                       upper_repl;
    logic                       heaps_idle;
    logic                       out_load;
    logic [CW-1:0]              total;
    logic [CW+COUNT_W-1:0]      total_wide;
    logic signed [MEDIAN_W-1:0] median;

    rmth_heap #(
        .DEPTH  (LOWER_DEPTH),
        .IS_MAX (1'b1)
    ) u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lower_cmd),
        .busy  (lower_busy),
        .top   (lower_top),
        .size  (lower_size)
    );

    rmth_heap #(
        .DEPTH  (UPPER_DEPTH),
        .IS_MAX (1'b0)
    ) u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (upper_cmd),
        .busy  (upper_busy),
        .top   (upper_top),
        .size  (upper_size)
    );

    assign v             = $signed(s_axis_tdata);
    assign s_axis_tready = (state_reg == T_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign total         = CW'(lower_size) + CW'(upper_size);
    assign total_wide    = (CW + COUNT_W)'(total);
    assign full          = (total >= CW'(CAPACITY));
    assign lower_extra   = (CW'(lower_size) > CW'(upper_size));
    assign lower_repl    = lower_extra && (v < lower_top);
    assign upper_repl    = !lower_extra && (upper_size != '0) && (v > upper_top);
    assign heaps_idle    = !lower_busy && !upper_busy;
    assign out_load      = (state_reg == T_RESULT) && heaps_idle
                         && (!m_tvalid_reg || m_axis_tready);

    always_comb
    begin
        lower_cmd = '{valid: 1'b0, op: HEAP_PUSH, value: v};
        upper_cmd = '{valid: 1'b0, op: HEAP_PUSH, value: v};
        case (state_reg)
            T_IDLE:
            begin
                if (accept && !full)
                begin
                    if (lower_extra)
                    begin
                        if (lower_repl)
                        begin
                            lower_cmd.valid = 1'b1;
                            lower_cmd.op    = HEAP_REPLACE;
                        end
                        else
                        begin
                            upper_cmd.valid = 1'b1;
                        end
                    end
                    else if (upper_repl)
                    begin
                        upper_cmd.valid = 1'b1;
                        upper_cmd.op    = HEAP_REPLACE;
                    end
                    else
                    begin
                        lower_cmd.valid = 1'b1;
                    end
                end
            end
            T_FIRST:
            begin
                lower_cmd.value = second_val_reg;
                upper_cmd.value = second_val_reg;
                if (heaps_idle && second_pend_reg)
                begin
                    upper_cmd.valid = second_upper_reg;
                    lower_cmd.valid = !second_upper_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (lower_extra)
        begin
            median = {lower_top, 1'b0};
        end
        else if (lower_size != '0)
        begin
            median = {lower_top[SAMPLE_W-1], lower_top}
                   + {upper_top[SAMPLE_W-1], upper_top};
        end
        else
        begin
            median = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            second_pend_reg  <= 1'b0;
            second_upper_reg <= 1'b0;
            second_val_reg   <= '0;
            rej_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tuser_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        rej_reg          <= full;
                        second_pend_reg  <= lower_repl || upper_repl;
                        second_upper_reg <= lower_extra;
                        second_val_reg   <= lower_extra ? lower_top : upper_top;
                        state_reg        <= full ? T_RESULT : T_FIRST;
                    end
                end
                T_FIRST:
                begin
                    if (heaps_idle)
                    begin
                        state_reg <= T_RESULT;
                    end
                end
                T_RESULT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= {{(OUT_TDATA_W - MEDIAN_W - COUNT_W){1'b0}},
                                         total_wide[COUNT_W-1:0], median};
                        m_tuser_reg  <= rej_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_tvalid_reg;
    assign m_axis_tdata    = m_tdata_reg;
    assign m_axis_tuser[0] = m_tuser_reg;

endmodule

// ===== hw/rtl/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/rmth_heap.sv =====
// ----------------------------------------------------------------------------
// rmth_heap
// One binary heap in a RAM, with a push (sift up) and a replace-top (sift
// down) engine that walks one level per cycle. The top is kept in a register.
// ----------------------------------------------------------------------------
module rmth_heap #(
    parameter int DEPTH  = 512,
    parameter bit IS_MAX = 1'b1,
    localparam int SW = $clog2(DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rmth_pkg::heap_cmd_t                  cmd,
    output logic                                 busy,
    output logic signed [rmth_pkg::SAMPLE_W-1:0] top,
    output logic [SW-1:0]                        size
);

    import rmth_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = AW + 2;

    typedef enum logic [1:0]
    {
        H_IDLE,
        H_UP,
        H_DOWN
    } hstate_t;

    hstate_t                    state_reg, state_next;
    logic [IW-1:0]              pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] val_reg, val_next;
    logic [SW-1:0]              size_reg, size_next;
    logic signed [SAMPLE_W-1:0] top_reg, top_next;

    logic                       we;
    logic [IW-1:0]              waddr;
    logic [SAMPLE_W-1:0]        wdata;
    logic [IW-1:0]              raddr_a;
    logic [IW-1:0]              raddr_b;
    logic [SAMPLE_W-1:0]        rdata_a;
    logic [SAMPLE_W-1:0]        rdata_b;
    logic signed [SAMPLE_W-1:0] child_a;
    logic signed [SAMPLE_W-1:0] child_b;
    logic signed [SAMPLE_W-1:0] best;
    logic [IW-1:0]              best_pos;
    logic [IW-1:0]              n_ext;

    function automatic logic better(input logic signed [SAMPLE_W-1:0] a,
                                    input logic signed [SAMPLE_W-1:0] b);
        return IS_MAX ? (a > b) : (a < b);
    endfunction

    function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] p);
        return (p - IW'(1)) >> 1;
    endfunction

    function automatic logic [IW-1:0] left_of(input logic [IW-1:0] p);
        return {p[IW-2:0], 1'b1};
    endfunction

    rmth_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr[AW-1:0]),
        .wdata   (wdata),
        .raddr_a (raddr_a[AW-1:0]),
        .raddr_b (raddr_b[AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign child_a = $signed(rdata_a);
    assign child_b = $signed(rdata_b);
    assign n_ext   = IW'(size_reg);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        size_next  = size_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = val_reg;
        best       = val_reg;
        best_pos   = pos_reg;

        case (state_reg)
            H_IDLE:
            begin
                if (cmd.valid)
                begin
                    val_next = cmd.value;
                    if (cmd.op == HEAP_PUSH)
                    begin
                        size_next = size_reg + SW'(1);
                        if (size_reg == '0)
                        begin
                            we    = 1'b1;
                            waddr = '0;
                            wdata = cmd.value;
                        end
                        else
                        begin
                            pos_next   = IW'(size_reg);
                            state_next = H_UP;
                        end
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = H_DOWN;
                    end
                end
            end
            H_UP:
            begin
                we = 1'b1;
                if (pos_reg != '0 && better(val_reg, child_a))
                begin
                    wdata    = rdata_a;
                    pos_next = parent_of(pos_reg);
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            H_DOWN:
            begin
                if (left_of(pos_reg) < n_ext && better(child_a, best))
                begin
                    best     = child_a;
                    best_pos = left_of(pos_reg);
                end
                if (left_of(pos_reg) + IW'(1) < n_ext && better(child_b, best))
                begin
                    best     = child_b;
                    best_pos = left_of(pos_reg) + IW'(1);
                end
                we    = 1'b1;
                wdata = best;
                if (best_pos != pos_reg)
                begin
                    pos_next = best_pos;
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase

        raddr_a = (state_next == H_UP) ? parent_of(pos_next) : left_of(pos_next);
        raddr_b = left_of(pos_next) + IW'(1);
        top_next = (we && waddr == '0) ? $signed(wdata) : top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
            pos_reg   <= '0;
            val_reg   <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            pos_reg   <= pos_next;
            val_reg   <= val_next;
            top_reg   <= top_next;
        end
    end

    assign busy = (state_reg != H_IDLE);
    assign top  = top_reg;
    assign size = size_reg;

endmodule
